[design/mpc_pkg.sv]
// Shared package for the mesh packet crypto block: queue entry type, register
// indexes and the AES-128 round helpers. No dependencies.
`timescale 1ns / 1ps
package mpc_pkg;

  localparam logic [2:0] CFG_KEY_LOW    = 3'd0;
  localparam logic [2:0] CFG_KEY_HIGH   = 3'd1;
  localparam logic [2:0] CFG_NODE_ADDR  = 3'd2;
  localparam logic [2:0] CFG_VENDOR     = 3'd3;
  localparam logic [2:0] CFG_NODE_ID    = 3'd4;
  localparam logic [2:0] CFG_STATUS_REP = 3'd5;

  localparam logic [7:0] NONCE_TAG = 8'h0f;
  localparam logic [7:0] BLK_ONE   = 8'h01;
  localparam logic [15:0] CNT_MAX  = 16'hffff;

  typedef enum logic [0:0] {CMD_SEAL = 1'b0, CMD_OPEN = 1'b1} cmd_e;
  typedef enum logic [1:0] {B_IDLE, B_AES, B_OUT} back_state_e;
  typedef enum logic [1:0] {PH_NONCE, PH_MAC, PH_CTR, PH_RX} phase_e;

  typedef struct packed {
    cmd_e         cmd;
    logic [15:0]  counter;
    logic [159:0] data;  // seal: {payload, command}; open: received bytes
  } entry_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } aes_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte j of a block sits at bits [127-8j -: 8]
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int j = 0; j < 16; j++) begin
      r[127 - 8 * j -: 8] = t[j];
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] tw, n0, n1, n2, n3;
    tw = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    n0 = rk[127:96] ^ tw;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

[design/mesh_packet_crypto.sv]
// Top level of the mesh packet crypto block: configuration registers, front
// end queue and back end crypto sequencer. Depends on mpc_pkg and submodules.
//
// Input channel in_valid_i/in_stall_o carries one beat per packet: cmd_i 0
// seals an outgoing packet (counter, node id, command, vendor, payload), 1
// opens a received 20-byte packet. Output channel out_valid_o/out_stall_i
// returns the 20-byte result and the vendor and id match flags.
// A two-entry queue takes beats while the back end works. Each AES call
// runs on the single iterated round unit: an outgoing packet holds it for 3
// calls, an incoming one for 1. Sustained rate is set by that unit.
// The write port cfg_we_i/cfg_idx_i/cfg_data_i sets key, address, vendor,
// node id and status report code; write it only while the block is idle.
// Reset clears the configuration registers, sets the packet counter to 1 and node id to 0.
// A stalled output holds its beat; the back end waits, then the queue fills
// and in_stall_o rises.
`timescale 1ns / 1ps
module mesh_packet_crypto import mpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  command_code_i,
  input  logic [63:0] payload_low_i,
  input  logic [15:0] payload_high_i,
  input  logic [63:0] rx_low_i,
  input  logic [63:0] rx_mid_i,
  input  logic [31:0] rx_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_low_o,
  output logic [63:0] out_mid_o,
  output logic [31:0] out_high_o,
  output logic        vendor_match_o,
  output logic        id_match_o
);

  logic [63:0]  key_low_q, key_high_q;
  logic [31:0]  addr_q;
  logic [15:0]  vendor_q;
  logic [7:0]   status_q;
  logic         q_valid, q_pop;
  entry_t       q_head;
  aes_ctl_t     aes_ctl;
  logic [159:0] out_pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      addr_q     <= '0;
      vendor_q   <= '0;
      status_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:    key_low_q  <= cfg_data_i;
        CFG_KEY_HIGH:   key_high_q <= cfg_data_i;
        CFG_NODE_ADDR:  addr_q     <= cfg_data_i[31:0];
        CFG_VENDOR:     vendor_q   <= cfg_data_i[15:0];
        CFG_STATUS_REP: status_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .command_code_i,
    .payload_low_i, .payload_high_i, .rx_low_i, .rx_mid_i, .rx_high_i,
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_head_o (q_head)
  );

  mpc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_head_i  (q_head),
    .key_i     ({key_high_q, key_low_q}),
    .addr_i    (addr_q),
    .vendor_i  (vendor_q),
    .status_i  (status_q),
    .id_we_i   (cfg_we_i && (cfg_idx_i == CFG_NODE_ID)),
    .id_data_i (cfg_data_i[15:0]),
    .aes_ctl_o (aes_ctl),
    .out_valid_o,
    .out_stall_i,
    .out_pkt_o (out_pkt),
    .vendor_match_o,
    .id_match_o
  );

  assign out_low_o  = out_pkt[63:0];
  assign out_mid_o  = out_pkt[127:64];
  assign out_high_o = out_pkt[159:128];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_ctl.start |-> !aes_ctl.busy) else $error("AES started while busy");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_ctl.done |-> $past(aes_ctl.busy)) else $error("AES done without run");

endmodule

[design/mpc_front.sv]
// Front end: accepts input beats, stamps the packet counter on outgoing
// items and queues them for the back end. Depends on mpc_pkg.
`timescale 1ns / 1ps
module mpc_front import mpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  command_code_i,
  input  logic [63:0] payload_low_i,
  input  logic [15:0] payload_high_i,
  input  logic [63:0] rx_low_i,
  input  logic [63:0] rx_mid_i,
  input  logic [31:0] rx_high_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output entry_t      q_head_o
);

  entry_t      fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic [15:0] counter_q;
  logic        push;
  entry_t      ent;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_head_o   = fifo_q[rd_ptr_q];

  always_comb begin
    ent.cmd     = cmd_e'(cmd_i);
    ent.counter = counter_q;
    if (cmd_i == CMD_OPEN) begin
      ent.data = {rx_high_i, rx_mid_i, rx_low_i};
    end else begin
      ent.data = {72'd0, payload_high_i, payload_low_i, command_code_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      count_q   <= 2'd0;
      counter_q <= 16'd1;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
        if (cmd_i == CMD_SEAL) begin
          counter_q <= (counter_q == CNT_MAX) ? 16'd1 : counter_q + 16'd1;
        end
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= ent;
    end
  end

endmodule

[design/mpc_aes.sv]
// Iterative AES-128 encryption unit, one round per cycle with on-the-fly key
// expansion. Depends on mpc_pkg.
`timescale 1ns / 1ps
module mpc_aes import mpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  input  logic [127:0] data_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [127:0] result_o
);

  logic [127:0] s_q, rk_q, rk_nxt;
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic         busy_q, done_q;

  assign rk_nxt   = key_next(rk_q, rcon_q);
  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q    <= data_i ^ key_i;
      rk_q   <= key_i;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      s_q    <= aes_round(s_q, rnd_q == 4'd10) ^ rk_nxt;
      rk_q   <= rk_nxt;
      rcon_q <= xtime(rcon_q);
    end
  end

endmodule

[design/mpc_back.sv]
// Back end: runs the seal or open sequence on the AES unit, tracks the node
// id and holds the output register. Depends on mpc_pkg and mpc_aes.
`timescale 1ns / 1ps
module mpc_back import mpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  output logic         q_pop_o,
  input  entry_t       q_head_i,
  input  logic [127:0] key_i,
  input  logic [31:0]  addr_i,
  input  logic [15:0]  vendor_i,
  input  logic [7:0]   status_i,
  input  logic         id_we_i,
  input  logic [15:0]  id_data_i,
  output aes_ctl_t     aes_ctl_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [159:0] out_pkt_o,
  output logic         vendor_match_o,
  output logic         id_match_o
);

  back_state_e  state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [159:0] p_q, p_d;
  logic [15:0]  cnt_q, cnt_d, node_id_q, node_id_d;
  logic         vm_q, vm_d, im_q, im_d;
  logic         out_valid_q, out_valid_d, load_out;
  logic [159:0] out_pkt_q;
  logic         out_vm_q, out_im_q;
  logic         aes_start, aes_busy, aes_done;
  logic [127:0] aes_data, aes_res;
  logic [159:0] pr;
  logic [15:0]  target;

  mpc_aes u_aes (
    .clk_i, .rst_ni,
    .start_i (aes_start),
    .key_i,
    .data_i  (aes_data),
    .busy_o  (aes_busy),
    .done_o  (aes_done),
    .result_o(aes_res)
  );

  assign aes_ctl_o = '{start: aes_start, busy: aes_busy, done: aes_done};

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    node_id_d = id_we_i ? id_data_i : node_id_q;
    vm_d      = vm_q;
    im_d      = im_q;
    q_pop_o   = 1'b0;
    aes_start = 1'b0;
    aes_data  = '0;
    load_out  = 1'b0;
    pr        = '0;
    target    = '0;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          aes_start = 1'b1;
          cnt_d     = q_head_i.counter;
          state_d   = B_AES;
          if (q_head_i.cmd == CMD_SEAL) begin
            p_d = {q_head_i.data[87:8], vendor_i, q_head_i.data[7:0], node_id_q,
                   24'd0, q_head_i.counter};
            aes_data = {56'd0, NONCE_TAG, 8'h00, q_head_i.counter, BLK_ONE, addr_i};
            phase_d  = PH_NONCE;
            vm_d     = 1'b1;
            im_d     = 1'b1;
          end else begin
            p_d      = q_head_i.data;
            aes_data = {56'd0, q_head_i.data[39:0], addr_i[23:0], 8'h00};
            phase_d  = PH_RX;
          end
        end
      end
      B_AES: begin
        if (aes_done) begin
          unique case (phase_q)
            PH_NONCE: begin
              aes_start = 1'b1;
              aes_data  = aes_res ^ {8'd0, p_q[159:40]};
              phase_d   = PH_MAC;
            end
            PH_MAC: begin
              p_d[39:24] = aes_res[15:0];
              aes_start  = 1'b1;
              aes_data   = {56'd0, 8'h00, cnt_q, BLK_ONE, addr_i, 8'h00};
              phase_d    = PH_CTR;
            end
            PH_CTR: begin
              p_d[159:40] = p_q[159:40] ^ aes_res[119:0];
              state_d     = B_OUT;
            end
            PH_RX: begin
              pr = {p_q[159:56] ^ aes_res[103:0], p_q[55:0]};
              p_d = pr;
              vm_d = (pr[79:64] == vendor_i);
              im_d = 1'b0;
              if (vm_d) begin
                if (pr[63:56] == status_i) begin
                  target = {8'd0, pr[87:80]};
                  if (node_id_q == 16'd0) begin
                    node_id_d = target;
                  end
                end else begin
                  target = {8'd0, pr[31:24]};
                end
                im_d = (node_id_d == target) || (target == 16'd0);
              end
              state_d = B_OUT;
            end
            default: state_d = B_OUT;
          endcase
        end
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      phase_q     <= PH_NONCE;
      node_id_q   <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      node_id_q   <= node_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    cnt_q <= cnt_d;
    vm_q  <= vm_d;
    im_q  <= im_d;
    if (load_out) begin
      out_pkt_q <= p_q;
      out_vm_q  <= vm_q;
      out_im_q  <= im_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_pkt_o      = out_pkt_q;
  assign vendor_match_o = out_vm_q;
  assign id_match_o     = out_im_q;

endmodule
